// File: hw/rtl/tcc_pkg.sv
package tcc_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Character codes with special handling.
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_RD_WAIT,
    ST_RESP
  } tcc_state_t;

  typedef struct packed {
    logic accept;
    logic put_step;
    logic scr_read;
    logic scr_write;
    logic fill_write;
    logic rd_capture;
  } tcc_cmd_t;

  typedef struct packed {
    logic scroll_need;
    logic copy_end;
    logic fill_end;
  } tcc_stat_t;

endpackage

// File: hw/rtl/tcc_ram.sv
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/tcc_ctrl.sv
module tcc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_kind,
  input  tcc_pkg::tcc_stat_t stat,
  output tcc_pkg::tcc_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);
  import tcc_pkg::*;

  tcc_state_t state_r, state_nxt;
  logic       open_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new request may be taken while the previous result is being shown.
  assign open_w    = (state_r == ST_IDLE) || (state_r == ST_RESP);
  assign busy      = !open_w;
  assign out_valid = (state_r == ST_RESP);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        cmd.fill_write = 1'b1;
        if (stat.fill_end) state_nxt = ST_IDLE;
      end
      ST_IDLE, ST_RESP: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (in_kind)
            KIND_PUT:   state_nxt = ST_PUT;
            KIND_CLEAR: state_nxt = ST_FILL;
            KIND_READ:  state_nxt = ST_RD_WAIT;
            default:    state_nxt = ST_RESP;
          endcase
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PUT: begin
        cmd.put_step = 1'b1;
        state_nxt = stat.scroll_need ? ST_SCR_RD : ST_RESP;
      end
      ST_SCR_RD: begin
        cmd.scr_read = 1'b1;
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.scr_write = 1'b1;
        state_nxt = stat.copy_end ? ST_FILL : ST_SCR_RD;
      end
      ST_FILL: begin
        cmd.fill_write = 1'b1;
        if (stat.fill_end) state_nxt = ST_RESP;
      end
      ST_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt = ST_RESP;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

endmodule

// File: hw/rtl/tcc_datapath.sv
module tcc_datapath #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcc_pkg::tcc_cmd_t          cmd,
  output tcc_pkg::tcc_stat_t         stat,
  input  logic [1:0]                 in_kind,
  input  logic [7:0]                 in_char_code,
  input  logic [3:0]                 in_back_color,
  input  logic [3:0]                 in_fore_color,
  input  logic [tcc_pkg::POS_W-1:0]  in_cell_index,
  output logic [tcc_pkg::POS_W-1:0]  out_cursor_pos,
  output logic [tcc_pkg::CELL_W-1:0] out_cell_data,
  output logic                       out_scrolled
);
  import tcc_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CNW   = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RW    = $clog2(ROWS);
  localparam int RNW   = $clog2(ROWS + 1);
  localparam int PW    = $clog2(TAB_WIDTH);

  logic [7:0]        char_r;
  logic [3:0]        back_r, fore_r;
  logic              oor_r;
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [PW-1:0]     phase_r;
  logic [AW-1:0]     ptr_r;
  logic [CELL_W-1:0] cell_data_r;
  logic              scrolled_r;

  logic [CNW-1:0]    col_n;
  logic [RNW-1:0]    row_n;
  logic [PW-1:0]     phase_n;
  logic              printable;
  logic              wrap;
  logic [AW-1:0]     cur_pos;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  assign cur_pos   = AW'(32'(row_r) * COLUMNS + 32'(col_r));
  assign printable = !char_r[7] && (char_r >= CHAR_SPACE);

  // Cursor update for one put; the tab phase follows the column modulo the tab width.
  always_comb begin
    logic [CNW-1:0] col_t;
    logic [RNW-1:0] row_t;
    logic [PW-1:0]  phase_t;
    col_t   = CNW'(col_r);
    row_t   = RNW'(row_r);
    phase_t = phase_r;
    case (char_r)
      CHAR_BS: begin
        if (col_r != '0) begin
          col_t   = CNW'(col_r) - CNW'(1);
          phase_t = (phase_r == '0) ? PW'(TAB_WIDTH - 1) : phase_r - PW'(1);
        end
      end
      CHAR_TAB: begin
        col_t   = CNW'(col_r) + CNW'(TAB_WIDTH) - CNW'(phase_r);
        phase_t = '0;
      end
      CHAR_CR: begin
        col_t   = '0;
        phase_t = '0;
      end
      CHAR_LF: begin
        col_t   = '0;
        row_t   = RNW'(row_r) + RNW'(1);
        phase_t = '0;
      end
      default: begin
        if (printable) begin
          col_t   = CNW'(col_r) + CNW'(1);
          phase_t = (phase_r == PW'(TAB_WIDTH - 1)) ? '0 : phase_r + PW'(1);
        end
      end
    endcase
    wrap = (col_t >= CNW'(COLUMNS));
    if (wrap) begin
      col_t   = '0;
      row_t   = row_t + RNW'(1);
      phase_t = '0;
    end
    col_n   = col_t;
    row_n   = row_t;
    phase_n = phase_t;
  end

  assign stat.scroll_need = (row_n >= RNW'(ROWS));
  assign stat.copy_end    = (ptr_r == AW'(CELLS - COLUMNS - 1));
  assign stat.fill_end    = (ptr_r == AW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
      ptr_r   <= '0;
    end else begin
      if (cmd.accept && (in_kind == KIND_CLEAR)) begin
        col_r   <= '0;
        row_r   <= '0;
        phase_r <= '0;
        ptr_r   <= '0;
      end
      if (cmd.put_step) begin
        col_r   <= CW'(col_n);
        phase_r <= phase_n;
        ptr_r   <= '0;
        if (stat.scroll_need) begin
          row_r <= RW'(ROWS - 1);
        end else begin
          row_r <= RW'(row_n);
        end
      end
      if (cmd.scr_write || cmd.fill_write) begin
        ptr_r <= stat.fill_end ? '0 : ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_r      <= in_char_code;
      back_r      <= in_back_color;
      fore_r      <= in_fore_color;
      oor_r       <= (32'(in_cell_index) >= CELLS);
      cell_data_r <= '0;
      scrolled_r  <= 1'b0;
    end
    if (cmd.put_step && stat.scroll_need) begin
      scrolled_r <= 1'b1;
    end
    if (cmd.rd_capture) begin
      cell_data_r <= oor_r ? '0 : rd_data;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = BLANK_CELL;
    if (cmd.fill_write) begin
      wr_en = 1'b1;
    end else if (cmd.scr_write) begin
      wr_en   = 1'b1;
      wr_data = rd_data;
    end else if (cmd.put_step && printable) begin
      wr_en   = 1'b1;
      wr_addr = cur_pos;
      wr_data = {back_r, fore_r, char_r};
    end
  end

  // During a scroll the cell one row below is fetched in ST_SCR_RD, ahead of its write in ST_SCR_WR.
  assign rd_addr = cmd.scr_read ? (ptr_r + AW'(COLUMNS)) : AW'(in_cell_index);

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_cursor_pos = POS_W'(cur_pos);
  assign out_cell_data  = cell_data_r;
  assign out_scrolled   = scrolled_r;

endmodule

// File: hw/rtl/text_console_cursor_writer.sv
// Channel   Direction  Handshake                    Fields
// request   in         start high while busy low    in_kind, in_char_code, in_back_color,
//                                                   in_fore_color, in_cell_index
// result    out        out_valid strobe, one cycle  out_cursor_pos, out_cell_data, out_scrolled
//
// A put without scrolling passes through ST_PUT and a read through ST_RD_WAIT, while an
// unused kind goes straight to the result; a new request is taken in the cycle its
// predecessor's result is strobed. A scroll copies each row up and blanks the last row: the
// cell store has one write port, so each cell is read and rewritten in turn.
// A clear blanks every cell. After reset busy stays high while the store is blanked.
// The receiver cannot stall; each result is shown for exactly one cycle.
module text_console_cursor_writer #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [7:0]                 in_char_code,
  input  logic [3:0]                 in_back_color,
  input  logic [3:0]                 in_fore_color,
  input  logic [tcc_pkg::POS_W-1:0]  in_cell_index,
  output logic                       out_valid,
  output logic [tcc_pkg::POS_W-1:0]  out_cursor_pos,
  output logic [tcc_pkg::CELL_W-1:0] out_cell_data,
  output logic                       out_scrolled
);
  import tcc_pkg::*;

  tcc_cmd_t  cmd;
  tcc_stat_t stat;

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tcc_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .in_back_color  (in_back_color),
    .in_fore_color  (in_fore_color),
    .in_cell_index  (in_cell_index),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled)
  );

endmodule
